>>> rtl/assert_macros.svh
// assertion macros used by the tag controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define SATC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SATC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> rtl/satc_pkg.sv
// types, constants and helpers of the set-associative tag controller
`default_nettype none
package satc_pkg;

  localparam int unsigned ADDR_W   = 40;
  localparam int unsigned WORD_LSB = 2;
  localparam int unsigned WORD_W   = 4;
  localparam int unsigned SET_LSB  = 6;
  localparam int unsigned SET_W    = 6;
  localparam int unsigned TAG_LSB  = 12;
  localparam int unsigned TAG_W    = 28;
  localparam int unsigned NUM_SETS = 1 << SET_W;
  localparam int unsigned WAY_W    = 3;
  localparam int unsigned NUM_WAYS = 1 << WAY_W;
  localparam int unsigned LFSR_W   = 16;
  localparam int unsigned CNT_W    = 32;

  localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;
  localparam logic [LFSR_W-1:0] SEED_ZERO_SUBST = 16'h0001;

  typedef logic [SET_W-1:0]  set_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [LFSR_W-1:0] lfsr_t;

  // one set: valid bits and tags of all ways
  typedef struct packed {
    logic [NUM_WAYS-1:0]            valid;
    logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  // lookup decision for one access
  typedef struct packed {
    logic  hit;
    logic  evict;
    way_t  way;
    lfsr_t lfsr;
  } lookup_t;

  // fibonacci lfsr x^16+x^14+x^13+x^11+1, shifting right
  function automatic lfsr_t lfsr_next(lfsr_t v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/set_assoc_cache_tag_controller.sv
// top level: 8-way set-associative tag controller with random replacement
//
//   channel   dir  signals                                     beat when
//   ------    ---  ------------------------------------------  ----------------------
//   request   in   in_valid_i, in_stall_o, address_i           valid high, stall low
//   result    out  out_valid_o, out_stall_i, hit_o, ...        valid high, stall low
//   seed cfg  in   cfg_we_i, cfg_data_i                        write enable high
//
// one request beat per cycle sustained unless the result side stalls; requests pass the
// lookup stage, then the result register; the set memory's single read port is read on
// the request beat, the row is compared and written back in the lookup stage, and a
// write that hits the set read in the same cycle is forwarded
// reset clears control, counters and per-set init flags; no memory sweep is needed
// a stalled result backs up the lookup stage, which then stalls the request side
`default_nettype none
module set_assoc_cache_tag_controller (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [39:0] address_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        hit_o,
  output logic [5:0]  set_index_o,
  output logic [2:0]  way_o,
  output logic [3:0]  word_offset_o,
  output logic        evicted_valid_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] access_count_o
);
  import satc_pkg::*;
  `include "assert_macros.svh"

  // handshake
  logic in_beat;
  logic s1_adv;

  // lookup stage
  logic                s1_valid_q;
  set_t                s1_set_q;
  tag_t                s1_tag_q;
  logic [WORD_W-1:0]   s1_word_q;
  logic                byp_valid_q;
  row_t                byp_row_q;

  // per-set init flags: a set never written reads as all ways invalid
  logic [NUM_SETS-1:0] row_init_q;
  logic [NUM_SETS-1:0] row_init_d;

  row_t    rd_row;
  row_t    eff_row;
  row_t    wr_row;
  logic    ram_we;
  lookup_t lk;
  set_t    in_set;

  lfsr_t            lfsr_q;
  lfsr_t            lfsr_d;
  lfsr_t            seed_in;
  logic [CNT_W-1:0] hits_q, hits_d;
  logic [CNT_W-1:0] acc_q, acc_d;

  // result register
  logic              out_valid_q;
  logic              out_hit_q;
  set_t              out_set_q;
  way_t              out_way_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_evict_q;

  // the lookup stage moves on when the result register is free or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_beat    = in_valid_i && !in_stall_o;
  assign in_set     = address_i[SET_LSB +: SET_W];

  satc_tag_ram u_tag_ram (
    .clk_i    (clk_i),
    .rd_en_i  (in_beat),
    .rd_set_i (in_set),
    .rd_row_o (rd_row),
    .wr_en_i  (ram_we),
    .wr_set_i (s1_set_q),
    .wr_row_i (wr_row)
  );

  // forwarded row wins; an untouched set has no valid ways
  always_comb begin
    eff_row = rd_row;
    if (byp_valid_q) begin
      eff_row = byp_row_q;
    end else if (!row_init_q[s1_set_q]) begin
      eff_row.valid = '0;
    end
  end

  satc_way_sel u_way_sel (
    .row_i    (eff_row),
    .tag_i    (s1_tag_q),
    .lfsr_i   (lfsr_q),
    .lookup_o (lk)
  );

  // miss: install the tag in the chosen way
  always_comb begin
    wr_row              = eff_row;
    wr_row.valid[lk.way] = 1'b1;
    wr_row.tag[lk.way]   = s1_tag_q;
  end

  assign ram_we = s1_adv && !lk.hit;

  always_comb begin
    row_init_d = row_init_q;
    if (ram_we) begin
      row_init_d[s1_set_q] = 1'b1;
    end
  end

  assign seed_in = (cfg_data_i == '0) ? SEED_ZERO_SUBST : cfg_data_i;

  always_comb begin
    lfsr_d = lfsr_q;
    hits_d = hits_q;
    acc_d  = acc_q;
    if (cfg_we_i) begin
      lfsr_d = seed_in;
    end else if (s1_adv && lk.evict) begin
      lfsr_d = lk.lfsr;
    end
    if (s1_adv) begin
      if (lk.hit && (hits_q != '1)) begin
        hits_d = hits_q + CNT_W'(1);
      end
      if (acc_q != '1) begin
        acc_d = acc_q + CNT_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      row_init_q  <= '0;
      lfsr_q      <= SEED_RESET;
      hits_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_init_q <= row_init_d;
      lfsr_q     <= lfsr_d;
      hits_q     <= hits_d;
      acc_q      <= acc_d;
      if (in_beat) begin
        s1_valid_q  <= 1'b1;
        byp_valid_q <= ram_we && (in_set == s1_set_q);
      end else if (s1_adv) begin
        s1_valid_q  <= 1'b0;
        byp_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_set_q  <= in_set;
      s1_tag_q  <= address_i[TAG_LSB +: TAG_W];
      s1_word_q <= address_i[WORD_LSB +: WORD_W];
      byp_row_q <= wr_row;
    end
    if (s1_adv) begin
      out_hit_q   <= lk.hit;
      out_set_q   <= s1_set_q;
      out_way_q   <= lk.way;
      out_word_q  <= s1_word_q;
      out_evict_q <= lk.evict;
    end
  end

  // counters are already the post-access values when the result is loaded
  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign set_index_o     = out_set_q;
  assign way_o           = out_way_q;
  assign word_offset_o   = out_word_q;
  assign evicted_valid_o = out_evict_q;
  assign hit_count_o     = hits_q;
  assign access_count_o  = acc_q;

  `SATC_ASSERT(a_evict_full_set, clk_i, rst_ni, (s1_adv && lk.evict) |-> (&eff_row.valid), "eviction from a set with a free way")
  `SATC_ASSERT(a_init_after_write, clk_i, rst_ni, ram_we |=> row_init_q[$past(s1_set_q)], "set written but init flag clear")
  `SATC_ASSERT(a_hits_le_accesses, clk_i, rst_ni, out_valid_o |-> (hit_count_o <= access_count_o), "hit count above access count")
  `SATC_NEVER(a_lfsr_nonzero, clk_i, rst_ni, lfsr_q == '0, "victim lfsr locked at zero")

endmodule
`default_nettype wire

>>> rtl/satc_tag_ram.sv
// set memory: one row of valid bits and tags per set, registered read
`default_nettype none
module satc_tag_ram (
  input  wire                clk_i,
  input  wire                rd_en_i,
  input  wire satc_pkg::set_t rd_set_i,
  output satc_pkg::row_t     rd_row_o,
  input  wire                wr_en_i,
  input  wire satc_pkg::set_t wr_set_i,
  input  wire satc_pkg::row_t wr_row_i
);
  import satc_pkg::*;

  row_t mem_q [NUM_SETS];
  row_t rd_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_set_i] <= wr_row_i;
    end
  end

  // read-before-write on a same-set collision
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_set_i];
    end
  end

  assign rd_row_o = rd_row_q;

endmodule
`default_nettype wire

>>> rtl/satc_way_sel.sv
// tag compare, lowest free way search and random victim pick for one set
`default_nettype none
module satc_way_sel (
  input  wire satc_pkg::row_t  row_i,
  input  wire satc_pkg::tag_t  tag_i,
  input  wire satc_pkg::lfsr_t lfsr_i,
  output satc_pkg::lookup_t    lookup_o
);
  import satc_pkg::*;

  logic [NUM_WAYS-1:0] match;
  logic                any_free;
  way_t                hit_way;
  way_t                free_way;
  lfsr_t               lfsr_adv;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    any_free = 1'b0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      match[w] = row_i.valid[w] && (row_i.tag[w] == tag_i);
      if (match[w]) begin
        hit_way = way_t'(w);
      end
      if (!row_i.valid[w]) begin
        free_way = way_t'(w);
        any_free = 1'b1;
      end
    end
  end

  assign lfsr_adv = lfsr_next(lfsr_i);

  always_comb begin
    lookup_o.hit   = |match;
    lookup_o.evict = !(|match) && !any_free;
    lookup_o.lfsr  = lfsr_adv;
    if (|match) begin
      lookup_o.way = hit_way;
    end else if (any_free) begin
      lookup_o.way = free_way;
    end else begin
      lookup_o.way = lfsr_adv[WAY_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the 8-way set-associative tag controller
`default_nettype none
module tb;
  import satc_pkg::*;

  // cycles to let pass after the last result before a seed write or the end
  localparam int unsigned SETTLE_CYCLES = 4;
  // receiver hold-off long enough to back the block up into the request side
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned HOT_SETS = 4;
  localparam int unsigned HOT_TAGS = 12;

  // one result beat as the block should present it
  typedef struct {
    logic                hit;
    set_t                set_index;
    way_t                way;
    logic [WORD_W-1:0]   word_offset;
    logic                evicted_valid;
    logic [CNT_W-1:0]    hit_count;
    logic [CNT_W-1:0]    access_count;
  } access_result_t;

  // clock, reset and block inputs, all known from time zero
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [LFSR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic [ADDR_W-1:0] address = '0;
  logic              out_stall = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic              hit;
  set_t              set_index;
  way_t              way;
  logic [WORD_W-1:0] word_offset;
  logic              evicted_valid;
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  access_count;

  // shadow copy of the tag array, replacement lfsr and counters
  bit                tag_valid [NUM_SETS][NUM_WAYS];
  tag_t              tag_store [NUM_SETS][NUM_WAYS];
  lfsr_t             victim_state;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  access_total;

  // results still owed by the block, oldest first
  access_result_t    pending_results [$];
  int unsigned       mismatch_count = 0;

  // receiver behavior, set by the test sequence and carried out by the stall process
  int unsigned       stall_pct = 0;
  int unsigned       hold_wanted = 0;
  int unsigned       hold_served = 0;
  int unsigned       hold_left = 0;
  int unsigned       stall_cycle = 0;

  // small pools of sets and tags so that hits and evictions happen often
  set_t              hot_sets [HOT_SETS];
  tag_t              hot_tags [HOT_TAGS];

  set_assoc_cache_tag_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .address_i       (address),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .hit_o           (hit),
    .set_index_o     (set_index),
    .way_o           (way),
    .word_offset_o   (word_offset),
    .evicted_valid_o (evicted_valid),
    .hit_count_o     (hit_count),
    .access_count_o  (access_count)
  );

  always #1 clk_i = ~clk_i;

  // predict one access and update the shadow state the way the block does
  function automatic access_result_t lookup_access(logic [ADDR_W-1:0] a);
    access_result_t r;
    set_t           s;
    tag_t           t;
    bit             filled;
    logic           fb;
    s = a[SET_LSB +: SET_W];
    t = a[TAG_LSB +: TAG_W];
    r.hit = 1'b0;
    r.way = '0;
    r.evicted_valid = 1'b0;
    r.set_index = s;
    r.word_offset = a[WORD_LSB +: WORD_W];
    // tag compare over the valid ways, lowest matching way wins
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!r.hit && tag_valid[s][w] && tag_store[s][w] == t) begin
        r.hit = 1'b1;
        r.way = way_t'(w);
      end
    end
    if (!r.hit) begin
      // miss: lowest invalid way first
      filled = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!filled && !tag_valid[s][w]) begin
          filled = 1'b1;
          r.way = way_t'(w);
        end
      end
      // set full: step the victim lfsr once and take its low bits over all ways
      if (!filled) begin
        fb = victim_state[0] ^ victim_state[2] ^ victim_state[3] ^ victim_state[5];
        victim_state = {fb, victim_state[LFSR_W-1:1]};
        r.way = victim_state[WAY_W-1:0];
        r.evicted_valid = 1'b1;
      end
      tag_valid[s][r.way] = 1'b1;
      tag_store[s][r.way] = t;
    end
    // both counters stick at all ones
    if (r.hit && hit_total != '1) hit_total++;
    if (access_total != '1) access_total++;
    r.hit_count = hit_total;
    r.access_count = access_total;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] make_address(tag_t t, set_t s, logic [WORD_W-1:0] w);
    return {t, s, w, 2'b00};
  endfunction

  // mostly hot sets and tags with random word and byte bits, the rest fully random
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    a = ADDR_W'({$urandom(), $urandom()});
    if ($urandom_range(99) < 75) begin
      a[SET_LSB +: SET_W] = hot_sets[$urandom_range(HOT_SETS-1)];
      a[TAG_LSB +: TAG_W] = hot_tags[$urandom_range(HOT_TAGS-1)];
    end
    return a;
  endfunction

  // fresh hot pools; the extremes of set and tag are always among them
  task automatic shuffle_hot_pools();
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int i = 2; i < HOT_SETS; i++) hot_sets[i] = set_t'($urandom());
    hot_tags[0] = '0;
    hot_tags[1] = '1;
    for (int i = 2; i < HOT_TAGS; i++) hot_tags[i] = tag_t'($urandom());
  endtask

  // offer one request beat and hold it until the block takes it; valid stays up
  task automatic send_access(logic [ADDR_W-1:0] a);
    access_result_t expected;
    in_valid <= 1'b1;
    address <= a;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    // beat taken at this edge
    expected = lookup_access(a);
    pending_results.insert(pending_results.size(), expected);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // stop offering, wait for every owed result, then let the pipeline settle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // seed write; a zero seed loads one, and the lfsr restarts from the seed
  task automatic write_seed(logic [LFSR_W-1:0] v);
    wait_results_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    victim_state = (v == '0) ? SEED_ZERO_SUBST : v;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // random traffic in bursts with gaps; optional full pauses every so many beats
  task automatic run_random_accesses(int unsigned count, int unsigned gap_max,
                                     int unsigned pause_every);
    int unsigned burst_left;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_every > 0 && i > 0 && i % pause_every == 0) wait_results_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        if (gap_max > 0) idle_cycles($urandom_range(gap_max));
      end
      send_access(pick_address());
      burst_left--;
    end
  endtask

  // corners of the address, hits, fills and evictions under the reset seed
  task automatic test_directed_lookups();
    stall_pct = 0;
    send_access(make_address('0, '0, '0));
    send_access(40'h00_0000_0003);
    send_access('1);
    send_access(make_address('1, '1, '0));
    send_access(make_address('0, set_t'(1), 4'hA));
    // fill every way of one set, then force two replacements and revisit
    for (int i = 1; i <= NUM_WAYS; i++) begin
      send_access(make_address(tag_t'(i), set_t'(5), 4'(i)));
    end
    send_access(make_address(tag_t'(9), set_t'(5), 4'hF));
    send_access(make_address(tag_t'(10), set_t'(5), 4'h0));
    send_access(make_address(tag_t'(9), set_t'(5), 4'h5));
    send_access(make_address(tag_t'(1), set_t'(5), 4'h3));
  endtask

  // victim choice after seed writes: zero, all ones and one
  task automatic test_seed_writes();
    logic [LFSR_W-1:0] seeds [3];
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = LFSR_W'(1);
    stall_pct = 0;
    for (int k = 0; k < 3; k++) begin
      write_seed(seeds[k]);
      // set 5 is full, so each new tag replaces a line
      for (int i = 0; i < 6; i++) begin
        send_access(make_address(tag_t'(32 + 8 * k + i), set_t'(5), 4'(i)));
      end
    end
  endtask

  // random traffic under several seeds and idling mixes
  task automatic test_random_traffic();
    shuffle_hot_pools();
    write_seed(LFSR_W'($urandom_range(65535, 1)));
    stall_pct = 0;
    run_random_accesses(200, 0, 0);
    shuffle_hot_pools();
    write_seed(LFSR_W'($urandom_range(65535, 1)));
    stall_pct = 30;
    run_random_accesses(300, 6, 0);
    write_seed(SEED_RESET);
    stall_pct = 60;
    run_random_accesses(250, 3, 0);
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    shuffle_hot_pools();
    stall_pct = 20;
    hold_wanted++;
    run_random_accesses(80, 0, 0);
    hold_wanted++;
    run_random_accesses(70, 2, 0);
  endtask

  // sender stops now and then until every result is back
  task automatic test_sender_pauses();
    write_seed(LFSR_W'($urandom_range(65535, 1)));
    stall_pct = 40;
    run_random_accesses(250, 4, 40);
  endtask

  // receiver stall: long hold-offs on request, otherwise random or periodic
  always @(posedge clk_i) begin
    stall_cycle++;
    if (hold_served != hold_wanted) begin
      hold_served++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_pct == 0) begin
      out_stall <= 1'b0;
    end else if (stall_cycle[7]) begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end else begin
      // periodic stretch so stalls land on a fixed phase too
      out_stall <= (stall_cycle % 8 < stall_pct / 13);
    end
  end

  task automatic check_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // result beat: compare with the oldest owed result
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, way %0d set %0d", $time, way,
                 set_index);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", CNT_W'(want.hit), CNT_W'(hit));
        check_field("set_index", CNT_W'(want.set_index), CNT_W'(set_index));
        check_field("way", CNT_W'(want.way), CNT_W'(way));
        check_field("word_offset", CNT_W'(want.word_offset), CNT_W'(word_offset));
        check_field("evicted_valid", CNT_W'(want.evicted_valid), CNT_W'(evicted_valid));
        check_field("hit_count", want.hit_count, hit_count);
        check_field("access_count", want.access_count, access_count);
      end
    end
  end

  initial begin
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        tag_valid[s][w] = 1'b0;
        tag_store[s][w] = '0;
      end
    end
    victim_state = SEED_RESET;
    hit_total = '0;
    access_total = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lookups();
    test_seed_writes();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pauses();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

>>> set_assoc_cache_tag_controller.f
+incdir+rtl
rtl/satc_pkg.sv
rtl/satc_tag_ram.sv
rtl/satc_way_sel.sv
rtl/set_assoc_cache_tag_controller.sv
tb/tb.sv
